// ===== rtl/u16u8_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types, constants and the UTF-8 encoder for the UTF-16BE to UTF-8
// transcoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam logic [15:0] HiSurLo  = 16'hD800;
  localparam logic [15:0] HiSurHi  = 16'hDBFF;
  localparam logic [15:0] LoSurLo  = 16'hDC00;
  localparam logic [15:0] LoSurHi  = 16'hDFFF;
  localparam logic [20:0] Lim1Byte = 21'h00080;
  localparam logic [20:0] Lim2Byte = 21'h00800;
  localparam logic [20:0] Lim3Byte = 21'h10000;
  localparam logic [10:0] SupBias  = 11'h040;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      nbytes;
    logic            done;
    logic            status;
  } job_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      nbytes;
  } enc_t;

  function automatic enc_t encode(input logic [20:0] c);
    enc_t e;
    e = '0;
    if (c < Lim1Byte) begin
      e.bytes[0] = {1'b0, c[6:0]};
      e.nbytes   = 3'd1;
    end else if (c < Lim2Byte) begin
      e.bytes[0] = {3'b110, c[10:6]};
      e.bytes[1] = {2'b10, c[5:0]};
      e.nbytes   = 3'd2;
    end else if (c < Lim3Byte) begin
      e.bytes[0] = {4'b1110, c[15:12]};
      e.bytes[1] = {2'b10, c[11:6]};
      e.bytes[2] = {2'b10, c[5:0]};
      e.nbytes   = 3'd3;
    end else begin
      e.bytes[0] = {5'b11110, c[20:18]};
      e.bytes[1] = {2'b10, c[17:12]};
      e.bytes[2] = {2'b10, c[11:6]};
      e.bytes[3] = {2'b10, c[5:0]};
      e.nbytes   = 3'd4;
    end
    return e;
  endfunction

endpackage

// ===== rtl/utf16be_to_utf8_transcoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf16be_to_utf8_transcoder_top
// UTF-16BE to UTF-8 transcoder.
//
// Input side is a queue write port: a byte request is taken when push is high
// and full is low; end_of_name marks the final byte of a name. Output side is
// a queue read port: the oldest request sits on out_byte/byte_valid/
// name_done/status while empty is low and leaves when pop is high.
// Each code point gives one to four output bytes; the last request of a name
// has name_done set and carries the status (1 = malformed). A name with
// nothing to emit at its end gives one request with byte_valid low.
// The job for the byte that completes a code point goes into the job queue,
// then into the emitter's job register, and its first byte is then
// registered as an output request. Input bytes are taken one per cycle while
// the queue has room; the emitter gives one byte per cycle while the receiver
// pops. A stalled receiver fills the output register, then the
// two-entry job queue, then raises full. Synchronous reset empties both and
// clears the pairing, surrogate and error state.
// ----------------------------------------------------------------------------
module utf16be_to_utf8_transcoder_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       end_of_name,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       name_done,
  output logic       status
);

  logic            accept;
  logic            front_valid;
  u16u8_pkg::job_t front_job;
  logic            q_valid;
  u16u8_pkg::job_t q_job;
  logic            q_take;

  assign accept = push && !full;

  u16u8_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .in_byte     (in_byte),
    .end_of_name (end_of_name),
    .job_valid   (front_valid),
    .job         (front_job)
  );

  u16u8_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (front_valid),
    .wr_data  (front_job),
    .full     (full),
    .rd_en    (q_take),
    .rd_valid (q_valid),
    .rd_data  (q_job)
  );

  u16u8_back u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (q_valid),
    .job_in     (q_job),
    .job_take   (q_take),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .name_done  (name_done),
    .status     (status)
  );

endmodule

// ===== rtl/u16u8_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_front
// Pairs input bytes into code units, tracks surrogates and errors, and
// produces one encoded job per code point or name end.
// ----------------------------------------------------------------------------
module u16u8_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        in_byte,
  input  logic              end_of_name,
  output logic              job_valid,
  output u16u8_pkg::job_t   job
);

  logic       half_unit_held, half_unit_held_next;
  logic [7:0] held_high_byte, held_high_byte_next;
  logic       surrogate_open, surrogate_open_next;
  logic [9:0] surrogate_bits, surrogate_bits_next;
  logic       error_seen, error_seen_next;

  logic [15:0]       unit;
  logic [20:0]       cp;
  logic              emit;
  u16u8_pkg::enc_t   enc;

  assign unit = {held_high_byte, in_byte};
  assign enc  = u16u8_pkg::encode(cp);

  always_comb begin
    half_unit_held_next = half_unit_held;
    held_high_byte_next = held_high_byte;
    surrogate_open_next = surrogate_open;
    surrogate_bits_next = surrogate_bits;
    error_seen_next     = error_seen;
    emit                = 1'b0;
    cp                  = {5'd0, unit};
    if (half_unit_held) begin
      half_unit_held_next = 1'b0;
      held_high_byte_next = '0;
      if (!error_seen) begin
        if (surrogate_open) begin
          surrogate_open_next = 1'b0;
          if (unit inside {[u16u8_pkg::LoSurLo:u16u8_pkg::LoSurHi]}) begin
            cp   = {({1'b0, surrogate_bits} + u16u8_pkg::SupBias), unit[9:0]};
            emit = 1'b1;
          end else begin
            error_seen_next = 1'b1;
          end
        end else if (unit inside {[u16u8_pkg::HiSurLo:u16u8_pkg::HiSurHi]}) begin
          surrogate_open_next = 1'b1;
          surrogate_bits_next = unit[9:0];
        end else if (unit inside {[u16u8_pkg::LoSurLo:u16u8_pkg::LoSurHi]}) begin
          error_seen_next = 1'b1;
        end else begin
          emit = 1'b1;
        end
      end
    end else if (!end_of_name) begin
      half_unit_held_next = 1'b1;
      held_high_byte_next = in_byte;
    end
  end

  always_comb begin
    job.bytes  = emit ? enc.bytes : '0;
    job.nbytes = emit ? enc.nbytes : 3'd0;
    job.done   = end_of_name;
    job.status = end_of_name && (error_seen_next || surrogate_open_next);
    job_valid  = accept && (emit || end_of_name);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_unit_held <= 1'b0;
      held_high_byte <= '0;
      surrogate_open <= 1'b0;
      surrogate_bits <= '0;
      error_seen     <= 1'b0;
    end else if (accept) begin
      if (end_of_name) begin
        half_unit_held <= 1'b0;
        held_high_byte <= '0;
        surrogate_open <= 1'b0;
        surrogate_bits <= '0;
        error_seen     <= 1'b0;
      end else begin
        half_unit_held <= half_unit_held_next;
        held_high_byte <= held_high_byte_next;
        surrogate_open <= surrogate_open_next;
        surrogate_bits <= surrogate_bits_next;
        error_seen     <= error_seen_next;
      end
    end
  end

endmodule

// ===== rtl/u16u8_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_queue
// Short job queue between the classifying front and the byte emitter.
// ----------------------------------------------------------------------------
module u16u8_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  u16u8_pkg::job_t   wr_data,
  output logic              full,
  input  logic              rd_en,
  output logic              rd_valid,
  output u16u8_pkg::job_t   rd_data
);

  u16u8_pkg::job_t                   slots [u16u8_pkg::QDepth];
  logic [u16u8_pkg::QPtrW-1:0]       wptr, rptr;
  logic [u16u8_pkg::QCntW-1:0]       count;

  localparam logic [u16u8_pkg::QPtrW-1:0] LastPtr = u16u8_pkg::QPtrW'(u16u8_pkg::QDepth - 1);
  localparam logic [u16u8_pkg::QCntW-1:0] FullCnt = u16u8_pkg::QCntW'(u16u8_pkg::QDepth);

  assign full     = (count == FullCnt);
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wptr <= (wptr == LastPtr) ? '0 : wptr + 1'b1;
      end
      if (rd_en) begin
        rptr <= (rptr == LastPtr) ? '0 : rptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !wr_en) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> rd_valid) else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FullCnt) else $error("queue count out of range");

endmodule

// ===== rtl/u16u8_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_back
// Takes jobs from the queue and emits their UTF-8 bytes one per cycle into
// the output register while it is empty or being popped.
// ----------------------------------------------------------------------------
module u16u8_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  u16u8_pkg::job_t   job_in,
  output logic              job_take,
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        out_byte,
  output logic              byte_valid,
  output logic              name_done,
  output logic              status
);

  u16u8_pkg::job_t job;
  logic            busy;
  logic            out_valid;
  logic            emit;
  logic            last_of_job;

  assign empty       = !out_valid;
  assign emit        = busy && (!out_valid || pop);
  assign last_of_job = (job.nbytes <= 3'd1);
  assign job_take    = job_valid && (!busy || (emit && last_of_job));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (job_take) begin
      busy <= 1'b1;
    end else if (emit && last_of_job) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      job <= job_in;
    end else if (emit) begin
      job.bytes  <= {8'd0, job.bytes[3:1]};
      job.nbytes <= job.nbytes - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte   <= (job.nbytes != 3'd0) ? job.bytes[0] : 8'd0;
      byte_valid <= (job.nbytes != 3'd0);
      name_done  <= job.done && last_of_job;
      status     <= job.done && job.status && last_of_job;
    end
  end

  a_empty_only_at_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !byte_valid) |-> name_done) else $error("empty request before name end");
  a_status_with_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> name_done) else $error("status without name end");
  a_job_len: assert property (@(posedge clk) disable iff (rst)
    busy |-> (job.nbytes <= 3'd4)) else $error("job length out of range");

endmodule
